@@ sv/tolerance_duplicate_table_assert.svh @@
// Assertion macros used by the tdt_checker file.
`ifndef TOLERANCE_DUPLICATE_TABLE_ASSERT_SVH
`define TOLERANCE_DUPLICATE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tdt_pkg.sv @@
package tdt_pkg;

  // Default table depth
  localparam int unsigned TdtCapacity = 256;

  // Field widths
  localparam int unsigned KeyW     = 32;
  localparam int unsigned EnergyTolW = 31;
  localparam int unsigned AngleTolW  = 16;
  localparam int unsigned TorsionW   = 10;
  // torsion_count * angle_tol stays below 2**26
  localparam int unsigned TotTolW    = 26;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 31;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENERGY_TOL    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_TOL     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TORSION_COUNT = 2'd2;

  // Register reset values
  localparam logic [EnergyTolW-1:0] EnergyTolRst    = 31'd3277;
  localparam logic [AngleTolW-1:0]  AngleTolRst     = 16'd1114;
  localparam logic [TorsionW-1:0]   TorsionCountRst = 10'd0;

  // Item function codes
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // One stored or candidate key
  typedef struct packed {
    logic signed [KeyW-1:0] energy;
    logic [KeyW-1:0]        angle;
  } tdt_key_t;

  // Candidate travelling along the cell row
  typedef struct packed {
    logic     valid;
    logic     match;
    tdt_key_t key;
  } tdt_tok_t;

endpackage

@@ sv/tdt_channels.sv @@
// Check item channel
interface tdt_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] energy;
  logic [31:0]        angle_total;

  modport source (output valid, output func, output energy, output angle_total, input ready);
  modport sink   (input valid, input func, input energy, input angle_total, output ready);
endinterface

// Result channel
interface tdt_out_if;
  logic valid;
  logic ready;
  logic duplicate;
  logic stored;
  logic table_full;

  modport source (output valid, output duplicate, output stored, output table_full,
                  input ready);
  modport sink   (input valid, input duplicate, input stored, input table_full,
                  output ready);
endinterface

@@ sv/tdt_cell.sv @@
module tdt_cell
  import tdt_pkg::*;
#(
  parameter int unsigned CNT_W = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [EnergyTolW-1:0] energy_tol_i,
  input  logic [TotTolW-1:0]    tot_tol_i,
  input  logic                  shift_i,
  input  tdt_key_t              shift_key_i,
  output tdt_key_t              shift_key_o,
  input  tdt_tok_t              tok_i,
  input  logic [CNT_W-1:0]      rem_i,
  output tdt_tok_t              tok_o,
  output logic [CNT_W-1:0]      rem_o
);

  tdt_key_t          entry_q;
  logic              valid_q;
  logic              match_q;
  tdt_key_t          key_q;
  logic [CNT_W-1:0]  rem_q;

  logic signed [KeyW:0] diff_e;
  logic signed [KeyW:0] diff_a;
  logic signed [KeyW:0] tol_e;
  logic signed [KeyW:0] tol_a;
  logic                 live;
  logic                 hit;

  // Compare the passing key with the held entry, both bounds strict
  always_comb begin
    diff_e = {entry_q.energy[KeyW-1], entry_q.energy} -
             {tok_i.key.energy[KeyW-1], tok_i.key.energy};
    diff_a = $signed({1'b0, entry_q.angle}) - $signed({1'b0, tok_i.key.angle});
    tol_e  = $signed({{(KeyW+1-EnergyTolW){1'b0}}, energy_tol_i});
    tol_a  = $signed({{(KeyW+1-TotTolW){1'b0}}, tot_tol_i});
    live   = (rem_i != '0);
    hit    = live && (diff_e < tol_e) && (diff_e > -tol_e) &&
             (diff_a < tol_a) && (diff_a > -tol_a);
  end

  // Hold the entry, shift a new one in on append
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= shift_key_i;
    end
  end

  // Advance the candidate valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  // Advance the candidate payload, count down the live entries
  always_ff @(posedge clk_i) begin
    match_q <= tok_i.match | hit;
    key_q   <= tok_i.key;
    rem_q   <= live ? rem_i - 1'b1 : '0;
  end

  assign shift_key_o = entry_q;
  assign tok_o       = '{valid: valid_q, match: match_q, key: key_q};
  assign rem_o       = rem_q;

endmodule

@@ sv/tolerance_duplicate_table.sv @@
// Channel   Dir  Payload                       Transaction
// item_i    in   func, energy, angle_total     valid && ready
// result_o  out  duplicate, stored, table_full valid && ready
// cfg       in   cfg_idx_i, cfg_wdata_i        cfg_we_i
//
// A check item is registered into launch_q, then the candidate walks the
// row of CAPACITY cells, one cell per cycle, and the result is then loaded.
// A clear item goes straight to the finish state. One item is in work at a time.
// The result register frees the input side; a stalled result holds the
// finished item until it is taken. Reset empties the table at once.
module tolerance_duplicate_table
  import tdt_pkg::*;
#(
  parameter int unsigned CAPACITY = TdtCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tdt_in_if.sink              item_i,
  tdt_out_if.source           result_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [EnergyTolW-1:0] energy_tol_q;
  logic [AngleTolW-1:0]  angle_tol_q;
  logic [TorsionW-1:0]   torsion_count_q;
  logic [TotTolW-1:0]    tot_tol_q;
  logic [CNT_W-1:0]      count_q;
  tdt_key_t              key_q;
  logic                  launch_q;
  logic                  clear_q;
  logic                  dup_q;
  logic                  out_valid_q;
  logic                  out_dup_q;
  logic                  out_stored_q;
  logic                  out_full_q;

  logic                  item_acc;
  logic                  out_free;
  logic                  finish;
  logic                  append;

  tdt_tok_t              tok   [CAPACITY+1];
  logic [CNT_W-1:0]      rem   [CAPACITY];
  tdt_key_t              chain [CAPACITY];

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign finish       = (state_q == S_FINISH) && out_free;
  assign append       = finish && !clear_q && !dup_q && (count_q != CapCnt);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_tol_q    <= EnergyTolRst;
      angle_tol_q     <= AngleTolRst;
      torsion_count_q <= TorsionCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENERGY_TOL:    energy_tol_q    <= cfg_wdata_i[EnergyTolW-1:0];
        CFG_ANGLE_TOL:     angle_tol_q     <= cfg_wdata_i[AngleTolW-1:0];
        CFG_TORSION_COUNT: torsion_count_q <= cfg_wdata_i[TorsionW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          state_d = (item_i.func == FUNC_CLEAR) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[CAPACITY].valid) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      clear_q  <= 1'b0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= item_acc && (item_i.func == FUNC_CHECK);
      if (item_acc) begin
        clear_q <= (item_i.func == FUNC_CLEAR);
      end
      if (finish && clear_q) begin
        count_q <= '0;
      end else if (append) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Capture the candidate and its total angle tolerance
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      key_q     <= '{energy: item_i.energy, angle: item_i.angle_total};
      tot_tol_q <= TotTolW'(torsion_count_q * angle_tol_q);
    end
    if (tok[CAPACITY].valid) begin
      dup_q <= tok[CAPACITY].match;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_dup_q    <= !clear_q && dup_q;
      out_stored_q <= append;
      out_full_q   <= !clear_q && !dup_q && (count_q == CapCnt);
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.duplicate  = out_dup_q;
  assign result_o.stored     = out_stored_q;
  assign result_o.table_full = out_full_q;

  // Row of cells
  assign tok[0]   = '{valid: launch_q, match: 1'b0, key: key_q};
  assign rem[0]   = count_q;
  assign chain[0] = key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i < CAPACITY - 1) begin : g_mid
      tdt_cell #(
        .CNT_W(CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .energy_tol_i(energy_tol_q),
        .tot_tol_i   (tot_tol_q),
        .shift_i     (append),
        .shift_key_i (chain[i]),
        .shift_key_o (chain[i+1]),
        .tok_i       (tok[i]),
        .rem_i       (rem[i]),
        .tok_o       (tok[i+1]),
        .rem_o       (rem[i+1])
      );
    end else begin : g_last
      tdt_cell #(
        .CNT_W(CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .energy_tol_i(energy_tol_q),
        .tot_tol_i   (tot_tol_q),
        .shift_i     (append),
        .shift_key_i (chain[i]),
        .shift_key_o (),
        .tok_i       (tok[i]),
        .rem_i       (rem[i]),
        .tok_o       (tok[i+1]),
        .rem_o       ()
      );
    end
  end

endmodule

@@ sv/tdt_checker.sv @@
module tdt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_dup_i,
  input logic out_stored_i,
  input logic out_full_i
);

`include "tolerance_duplicate_table_assert.svh"

  // At most one outcome flag per result
  `TDT_ASSERT_NOW(a_one_outcome, out_valid_i, $onehot0({out_dup_i, out_stored_i, out_full_i}), "more than one outcome flag set")

  // One item at a time: the input closes after a transaction
  `TDT_ASSERT_NEXT(a_single_item, in_valid_i && in_ready_i, !in_ready_i, "input still open after a transaction")

  // A new result appears only as the block returns to idle
  `TDT_ASSERT_NOW(a_result_idle, $rose(out_valid_i), in_ready_i, "result raised while busy")

  // A stalled result stays offered
  `TDT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

endmodule

bind tolerance_duplicate_table tdt_checker u_tdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_dup_i   (result_o.duplicate),
  .out_stored_i(result_o.stored),
  .out_full_i  (result_o.table_full)
);

@@ test/tdt_dup_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and register ports, keeps its own copy of the key
// table and compares every result transaction with the oldest expectation.
module tdt_dup_checker
  import tdt_pkg::*;
#(
  parameter int unsigned Capacity = TdtCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tdt_in_if                   item_i,
  tdt_out_if                  result_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic duplicate;
    logic stored;
    logic table_full;
  } verdict_t;

  logic [EnergyTolW-1:0] energy_tol_q;
  logic [AngleTolW-1:0]  angle_tol_q;
  logic [TorsionW-1:0]   torsion_q;

  logic [KeyW-1:0] key_energy_q [Capacity];
  logic [KeyW-1:0] key_angle_q  [Capacity];
  int unsigned     key_count_q;

  verdict_t awaited_verdicts[$];

  // Classify one item against the table and update the table as the block would
  function automatic verdict_t classify_key(input logic func, input logic [KeyW-1:0] energy,
                                            input logic [KeyW-1:0] angle);
    verdict_t          v;
    logic signed [KeyW:0] de;
    logic [KeyW:0]     ade;
    logic [KeyW-1:0]   ada;
    logic [KeyW-1:0]   tot_tol;
    bit                hit;
    v   = '0;
    hit = 1'b0;
    if (func == FUNC_CLEAR) begin
      key_count_q = 0;
      return v;
    end
    tot_tol = KeyW'(torsion_q) * KeyW'(angle_tol_q);
    // Scan every valid key; both comparisons are strict
    for (int unsigned i = 0; i < key_count_q; i++) begin
      de  = $signed({key_energy_q[i][KeyW-1], key_energy_q[i]}) - $signed({energy[KeyW-1], energy});
      ade = de[KeyW] ? (KeyW+1)'(-de) : (KeyW+1)'(de);
      ada = (key_angle_q[i] > angle) ? key_angle_q[i] - angle : angle - key_angle_q[i];
      if (ade < {2'b00, energy_tol_q} && ada < tot_tol) hit = 1'b1;
    end
    if (hit) begin
      v.duplicate = 1'b1;
    end else if (key_count_q < Capacity) begin
      key_energy_q[key_count_q] = energy;
      key_angle_q[key_count_q]  = angle;
      key_count_q++;
      v.stored = 1'b1;
    end else begin
      v.table_full = 1'b1;
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    if (!rst_ni) begin
      energy_tol_q = EnergyTolRst;
      angle_tol_q  = AngleTolRst;
      torsion_q    = TorsionCountRst;
      key_count_q  = 0;
      awaited_verdicts.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENERGY_TOL:    energy_tol_q = cfg_wdata_i[EnergyTolW-1:0];
          CFG_ANGLE_TOL:     angle_tol_q  = cfg_wdata_i[AngleTolW-1:0];
          CFG_TORSION_COUNT: torsion_q    = cfg_wdata_i[TorsionW-1:0];
          default: ;
        endcase
      end
      // Compare a finished result transaction with the oldest expectation
      if (result_i.valid && result_i.ready) begin
        if (awaited_verdicts.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual dup %b stored %b full %b",
                   $time, result_i.duplicate, result_i.stored, result_i.table_full);
        end else begin
          want = awaited_verdicts.pop_front();
          check_field("duplicate", want.duplicate, result_i.duplicate);
          check_field("stored", want.stored, result_i.stored);
          check_field("table_full", want.table_full, result_i.table_full);
        end
      end
      // Predict the result of an accepted item
      if (item_i.valid && item_i.ready) begin
        awaited_verdicts.push_back(classify_key(item_i.func, item_i.energy, item_i.angle_total));
      end
      pending_o = awaited_verdicts.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tdt_pkg::*;

  localparam int unsigned     StimItems    = 1470;
  localparam int unsigned     KeyHistory   = 300;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         fail_count;
  int unsigned         pending;

  // Stimulus state: current tolerances and recently sent keys
  longint      cur_energy_tol;
  longint      cur_angle_tol;
  bit          steady;
  int unsigned items_sent;
  tdt_key_t    recent_keys[$];

  tdt_in_if  item_if();
  tdt_out_if result_if();

  tolerance_duplicate_table #(
    .CAPACITY (TdtCapacity)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  tdt_dup_checker #(
    .Capacity (TdtCapacity)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .item_i       (item_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("[tolerance_duplicate_table] ERROR");
    $finish;
  end

  // Result side: stall for a random number of cycles before each transaction
  initial begin : result_sink
    int unsigned stall;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (result_if.valid !== 1'b1);
    end
  end

  // Offer one item after a random gap and hold it until the transaction
  task automatic send_item(input logic func, input logic [KeyW-1:0] energy,
                           input logic [KeyW-1:0] angle);
    int unsigned gap;
    tdt_key_t    k;
    gap = steady ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= func;
    item_if.energy      <= energy;
    item_if.angle_total <= angle;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    items_sent++;
    if (func == FUNC_CHECK) begin
      k.energy = energy;
      k.angle  = angle;
      recent_keys.push_back(k);
      if (recent_keys.size() > KeyHistory) void'(recent_keys.pop_front());
    end
  endtask

  // Drop valid and hold off until every expected result has been taken
  task automatic settle();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_tolerances(input logic [CfgDataW-1:0] etol, input logic [CfgDataW-1:0] atol,
                                input logic [CfgDataW-1:0] tcount);
    write_reg(CFG_ENERGY_TOL, etol);
    write_reg(CFG_ANGLE_TOL, atol);
    write_reg(CFG_TORSION_COUNT, tcount);
    cur_energy_tol = longint'(etol[EnergyTolW-1:0]);
    cur_angle_tol  = longint'(atol[AngleTolW-1:0]) * longint'(tcount[TorsionW-1:0]);
  endtask

  // Draw a new tolerance setting for a phase
  task automatic choose_tolerances();
    case ($urandom_range(0, 5))
      0: set_tolerances(31'h7FFF_FFFF, 31'd65535, 31'd1023);
      1: begin
        case ($urandom_range(0, 2))
          0:       set_tolerances(31'd0, 31'($urandom), 31'($urandom));
          1:       set_tolerances(31'($urandom), 31'd0, 31'($urandom));
          default: set_tolerances(31'($urandom), 31'($urandom), 31'd0);
        endcase
      end
      2: set_tolerances(CfgDataW'($urandom_range(1, 5000)), CfgDataW'($urandom_range(1, 2000)),
                        CfgDataW'($urandom_range(1, 8)));
      3: set_tolerances(CfgDataW'(EnergyTolRst), CfgDataW'(AngleTolRst),
                        CfgDataW'($urandom_range(0, 1023)));
      4: set_tolerances(31'($urandom), 31'($urandom), 31'($urandom));
      default: set_tolerances(CfgDataW'($urandom_range(1, 1 << 20)),
                              CfgDataW'($urandom_range(1, 65535)),
                              CfgDataW'($urandom_range(1, 64)));
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(CfgIdxSpare, 31'($urandom));
  endtask

  // Offset that lands on, just inside or just outside a tolerance
  function automatic longint near_offset(input longint tol);
    longint span;
    if (tol == 0) return longint'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0: return tol - 1;
      1: return tol;
      2: return -(tol - 1);
      3: return -tol;
      4: return 0;
      default: begin
        span = tol + tol / 4 + 1;
        return ($urandom_range(0, 1) != 0) ? longint'($urandom) % span
                                          : -(longint'($urandom) % span);
      end
    endcase
  endfunction

  // Mostly keys close to earlier ones, some extremes, some fully random
  function automatic tdt_key_t pick_key();
    tdt_key_t    k;
    tdt_key_t    h;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       k.energy = 32'sh8000_0000;
        1:       k.energy = 32'sh7FFF_FFFF;
        2:       k.energy = 32'sh0000_0000;
        default: k.energy = 32'shFFFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0:       k.angle = 32'h0000_0000;
        1:       k.angle = 32'hFFFF_FFFF;
        2:       k.angle = 32'h0000_0001;
        default: k.angle = 32'h7FFF_FFFF;
      endcase
    end else if (r <= 3 || recent_keys.size() == 0) begin
      k.energy = $urandom;
      k.angle  = $urandom;
    end else begin
      h = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      k.energy = 32'(longint'(h.energy) + near_offset(cur_energy_tol));
      k.angle  = 32'(longint'(h.angle) + near_offset(cur_angle_tol));
    end
    return k;
  endfunction

  initial begin : stimulus
    tdt_key_t    k;
    int unsigned phase;
    int unsigned n;
    item_if.valid       = 1'b0;
    item_if.func        = FUNC_CHECK;
    item_if.energy      = '0;
    item_if.angle_total = '0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_ENERGY_TOL;
    cfg_wdata           = '0;
    steady              = 1'b0;
    items_sent          = 0;
    cur_energy_tol      = longint'(EnergyTolRst);
    cur_angle_tol       = 0;
    rst_ni              = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset tolerances, torsion count zero, so nothing matches
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_CLEAR, $urandom, $urandom);
    send_item(FUNC_CHECK, 32'h8000_0000, 32'h0000_0000);
    send_item(FUNC_CHECK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // One torsion: probe both edges of each tolerance
    settle();
    write_reg(CFG_TORSION_COUNT, 31'd1);
    cur_angle_tol = longint'(AngleTolRst);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_CHECK, 32'd3276, 32'd1113);
    send_item(FUNC_CHECK, 32'd3277, 32'd0);
    send_item(FUNC_CHECK, -32'sd3276, 32'd1113);
    // Widest tolerances against extreme keys
    settle();
    set_tolerances(31'h7FFF_FFFF, 31'd65535, 31'd1023);
    send_item(FUNC_CHECK, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(FUNC_CHECK, 32'h8000_0000, 32'hFFFF_FFFF);
    // Zero tolerances, then zero torsion count alone
    settle();
    set_tolerances(31'd0, 31'd0, 31'd0);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    settle();
    set_tolerances(31'd5, 31'd65535, 31'd0);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    // Exact-match tolerances, plus a write to an unused index
    settle();
    write_reg(CfgIdxSpare, 31'h7FFF_FFFF);
    set_tolerances(31'd1, 31'd1, 31'd1);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_CHECK, 32'h0000_0001, 32'h0000_0000);
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);

    // Random phases, each with its own tolerances
    phase = 0;
    while (items_sent < StimItems) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Fill the table past capacity, then probe it with nearby keys
        set_tolerances(31'd0, 31'($urandom), 31'($urandom));
        send_item(FUNC_CLEAR, $urandom, $urandom);
        repeat (TdtCapacity + 12) send_item(FUNC_CHECK, $urandom, $urandom);
        settle();
        choose_tolerances();
        repeat (40) begin
          k = pick_key();
          send_item(FUNC_CHECK, k.energy, k.angle);
        end
      end else begin
        choose_tolerances();
        if ($urandom_range(0, 3) != 0) send_item(FUNC_CLEAR, $urandom, $urandom);
        n = $urandom_range(20, 100);
        repeat (n) begin
          if ($urandom_range(0, 24) == 0) begin
            send_item(FUNC_CLEAR, $urandom, $urandom);
          end else begin
            k = pick_key();
            send_item(FUNC_CHECK, k.energy, k.angle);
          end
        end
      end
      phase++;
    end

    // Drain and let the block run out before the verdict
    settle();
    repeat (TdtCapacity + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[tolerance_duplicate_table] OK");
    end else begin
      $display("[tolerance_duplicate_table] ERROR");
    end
    $finish;
  end

endmodule
